// ===== hw/rtl/mre_pkg.sv =====
// Package with shared constants, types and an address helper for the matrix region engine.
package mre_pkg;

  localparam int unsigned MaxRows   = 64;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned ElemWidth = 32;
  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned ColW      = $clog2(MaxCols);
  localparam int unsigned AddrW     = RowW + ColW;
  localparam int unsigned BoundW    = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ModeWrite     = 3'd0,
    ModeRead      = 3'd1,
    ModeMul       = 3'd2,
    ModeAdd       = 3'd3,
    ModeSub       = 3'd4,
    ModeFill      = 3'd5,
    ModeTrans     = 3'd6,
    ModeAntiTrans = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusOutside = 2'd1,
    StatusShape  = 2'd2,
    StatusRsvd   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgTopRow    = 2'd0,
    CfgLeftCol   = 2'd1,
    CfgBottomRow = 2'd2,
    CfgRightCol  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StReadA,
    StReadB,
    StWriteA,
    StWriteB,
    StDone
  } exec_state_e;

  // A classified command as handed from the front to the back.
  typedef struct packed {
    mode_e                 mode;
    logic                  is_region; // scalar, fill or transpose that touches memory
    logic [BoundW-1:0]     n_rows;
    logic [BoundW-1:0]     n_cols;
    logic [BoundW-1:0]     top;
    logic [BoundW-1:0]     left;
    logic [RowW-1:0]       row;
    logic [ColW-1:0]       col;
    logic [ElemWidth-1:0]  operand;
    status_e               status;
  } cmd_t;

  // Absolute store address of view-relative (r, c), wrapping like the store.
  function automatic logic [AddrW-1:0] elem_addr(input logic [BoundW-1:0] top,
                                                  input logic [BoundW-1:0] left,
                                                  input logic [BoundW-1:0] r,
                                                  input logic [BoundW-1:0] c);
    logic [BoundW:0] ar;
    logic [BoundW:0] ac;
    logic [AddrW+1:0] lin;
    begin
      ar  = {1'b0, top} + {1'b0, r};
      ac  = {1'b0, left} + {1'b0, c};
      lin = ({{(AddrW+1-BoundW){1'b0}}, ar} << ColW) +
            {{(AddrW+1-BoundW){1'b0}}, ac};
      elem_addr = lin[AddrW-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/mre_if.sv =====
// Valid/ready channel interfaces for commands, results and configuration writes.
interface mre_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    mode;
  logic [mre_pkg::RowW-1:0]      row;
  logic [mre_pkg::ColW-1:0]      col;
  logic [mre_pkg::ElemWidth-1:0] operand;
  modport source (output valid, mode, row, col, operand, input ready);
  modport sink (input valid, mode, row, col, operand, output ready);
endinterface

interface mre_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mre_pkg::ElemWidth-1:0] read_data;
  logic [1:0]                    status;
  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

interface mre_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mre_pkg::CfgIdxW-1:0] index;
  logic [mre_pkg::BoundW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/matrix_region_engine_core.sv =====
// Top level of the matrix region engine: front end, command queue and back-end sequencer.
// The engine keeps a 64 by 64 matrix of signed 32-bit words in one simple dual-port
// memory (one read and one write per cycle) and runs every command against the view set
// through the configuration channel. Scalar and fill commands read each view element
// and write it back, one element at a time. Transposes read both elements of each
// swapped pair and then write both back; an n by n view has n*(n-1)/2 pairs.
// A two-word command queue lets new commands be taken while one is executing, and a
// result register holds the finished word until the consumer takes it. Configuration
// is to be written only while the engine is idle. The memory has no reset; reading an
// unwritten entry returns garbage.
module matrix_region_engine_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  mre_cmd_if.sink   cmd,
  mre_cfg_if.sink   cfg,
  mre_rsp_if.source rsp
);
  mre_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_pop;

  mre_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd       (cmd),
    .cfg       (cfg),
    .q_cmd_o   (q_cmd),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  mre_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_cmd_i   (q_cmd),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .rsp       (rsp)
  );
endmodule

// ===== hw/rtl/mre_front.sv =====
// Front end: view registers, command classification and the command queue.
module mre_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mre_cmd_if.sink           cmd,
  mre_cfg_if.sink           cfg,
  output mre_pkg::cmd_t     q_cmd_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);
  logic [mre_pkg::BoundW-1:0] top_q, left_q, bottom_q, right_q;
  logic [mre_pkg::BoundW-1:0] bot_c, rgt_c, n_rows, n_cols;
  mre_pkg::cmd_t              cls;
  mre_pkg::cmd_t              fifo_q [mre_pkg::QueueDepth];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 cnt_q;
  logic                       push;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      left_q   <= '0;
      bottom_q <= mre_pkg::BoundW'(mre_pkg::MaxRows);
      right_q  <= mre_pkg::BoundW'(mre_pkg::MaxCols);
    end else if (cfg.valid) begin
      unique case (mre_pkg::cfg_idx_e'(cfg.index))
        mre_pkg::CfgTopRow:    top_q    <= cfg.data;
        mre_pkg::CfgLeftCol:   left_q   <= cfg.data;
        mre_pkg::CfgBottomRow: bottom_q <= cfg.data;
        mre_pkg::CfgRightCol:  right_q  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp bounds to the matrix and derive the view size.
  always_comb begin
    bot_c  = (bottom_q > mre_pkg::BoundW'(mre_pkg::MaxRows)) ?
             mre_pkg::BoundW'(mre_pkg::MaxRows) : bottom_q;
    rgt_c  = (right_q > mre_pkg::BoundW'(mre_pkg::MaxCols)) ?
             mre_pkg::BoundW'(mre_pkg::MaxCols) : right_q;
    n_rows = (bot_c > top_q) ? bot_c - top_q : '0;
    n_cols = (rgt_c > left_q) ? rgt_c - left_q : '0;
  end

  always_comb begin
    cls.mode      = mre_pkg::mode_e'(cmd.mode);
    cls.n_rows    = n_rows;
    cls.n_cols    = n_cols;
    cls.top       = top_q;
    cls.left      = left_q;
    cls.row       = cmd.row;
    cls.col       = cmd.col;
    cls.operand   = cmd.operand;
    cls.status    = mre_pkg::StatusOk;
    cls.is_region = 1'b0;
    unique case (mre_pkg::mode_e'(cmd.mode))
      mre_pkg::ModeWrite, mre_pkg::ModeRead: begin
        if ({1'b0, cmd.row} >= n_rows || {1'b0, cmd.col} >= n_cols)
          cls.status = mre_pkg::StatusOutside;
      end
      mre_pkg::ModeMul, mre_pkg::ModeAdd, mre_pkg::ModeSub, mre_pkg::ModeFill: begin
        cls.is_region = (n_rows != '0) && (n_cols != '0);
      end
      default: begin
        if (n_rows != n_cols || n_rows == '0) cls.status = mre_pkg::StatusShape;
        else cls.is_region = 1'b1;
      end
    endcase
  end

  assign cmd.ready = (cnt_q != 2'(mre_pkg::QueueDepth));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

// ===== hw/rtl/mre_back.sv =====
// Back end: sequencer that walks the store for each command and holds the result register.
module mre_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mre_pkg::cmd_t  q_cmd_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  mre_rsp_if.source      rsp
);
  logic [mre_pkg::ElemWidth-1:0] mem_q [mre_pkg::MaxRows*mre_pkg::MaxCols];

  mre_pkg::exec_state_e state_q, state_d;
  mre_pkg::cmd_t        cmd_q;
  logic [mre_pkg::BoundW-1:0] r_q, c_q, r_d, c_d;
  logic [mre_pkg::ElemWidth-1:0] a_q, rdata_q;
  logic [mre_pkg::ElemWidth-1:0] res_data_q;
  logic [1:0]                    res_status_q;
  logic                          res_valid_q;
  logic [mre_pkg::AddrW-1:0]     addr_a, addr_b, rd_addr, wr_addr;
  logic                          rd_en, wr_en, last, done_walk, swap;
  logic [mre_pkg::ElemWidth-1:0] wr_data;
  logic [mre_pkg::BoundW-1:0]    nm1, pr, pc;
  logic                          take;

  assign swap = (cmd_q.mode == mre_pkg::ModeTrans) || (cmd_q.mode == mre_pkg::ModeAntiTrans);
  assign nm1  = cmd_q.n_rows - 7'd1;

  // Partner element for the swap.
  always_comb begin
    if (cmd_q.mode == mre_pkg::ModeTrans) begin
      pr = c_q;
      pc = r_q;
    end else begin
      pr = nm1 - c_q;
      pc = nm1 - r_q;
    end
  end

  assign addr_a = mre_pkg::elem_addr(cmd_q.top, cmd_q.left, r_q, c_q);
  assign addr_b = mre_pkg::elem_addr(cmd_q.top, cmd_q.left, pr, pc);

  // Next element of the walk; scalar ops cover the full view, swaps one triangle.
  always_comb begin
    r_d = r_q;
    c_d = c_q + 7'd1;
    last = 1'b0;
    if (!swap) begin
      if (c_d == cmd_q.n_cols) begin
        c_d = '0;
        r_d = r_q + 7'd1;
        last = (r_d == cmd_q.n_rows);
      end
    end else if (cmd_q.mode == mre_pkg::ModeTrans) begin
      if (c_d == cmd_q.n_rows) begin
        r_d = r_q + 7'd1;
        c_d = r_q + 7'd2;
        last = (r_q + 7'd2 >= cmd_q.n_rows);
      end
    end else begin
      if (c_d + r_q + 7'd1 >= cmd_q.n_rows) begin
        c_d = '0;
        r_d = r_q + 7'd1;
        last = (r_q + 7'd2 >= cmd_q.n_rows);
      end
    end
  end

  // Transposes start at (0,1) or (0,0); an n=1 view has nothing to swap.
  assign done_walk = swap && (cmd_q.n_rows == 7'd1);

  assign take = q_valid_i && (state_q == mre_pkg::StIdle) && !res_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mre_pkg::StIdle:   if (take) state_d = q_cmd_i.is_region ? mre_pkg::StReadA :
                                             ((q_cmd_i.mode == mre_pkg::ModeRead &&
                                               q_cmd_i.status == mre_pkg::StatusOk) ?
                                              mre_pkg::StReadA : mre_pkg::StDone);
      mre_pkg::StReadA:  state_d = (!cmd_q.is_region) ? mre_pkg::StDone :
                                   (done_walk ? mre_pkg::StDone :
                                    (swap ? mre_pkg::StReadB : mre_pkg::StWriteA));
      mre_pkg::StReadB:  state_d = mre_pkg::StWriteA;
      mre_pkg::StWriteA: state_d = swap ? mre_pkg::StWriteB :
                                   (last ? mre_pkg::StDone : mre_pkg::StReadA);
      mre_pkg::StWriteB: state_d = last ? mre_pkg::StDone : mre_pkg::StReadA;
      mre_pkg::StDone:   state_d = mre_pkg::StIdle;
      default:           state_d = mre_pkg::StIdle;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_a;
    wr_en   = 1'b0;
    wr_addr = addr_a;
    wr_data = cmd_q.operand;
    unique case (state_q)
      mre_pkg::StReadA: begin
        rd_en = 1'b1;
        if (!cmd_q.is_region)
          rd_addr = mre_pkg::elem_addr(cmd_q.top, cmd_q.left, 7'(cmd_q.row), 7'(cmd_q.col));
      end
      mre_pkg::StReadB: begin
        rd_en   = 1'b1;
        rd_addr = addr_b;
      end
      mre_pkg::StWriteA: begin
        wr_en = 1'b1;
        unique case (cmd_q.mode)
          mre_pkg::ModeMul: wr_data = rdata_q * cmd_q.operand;
          mre_pkg::ModeAdd: wr_data = rdata_q + cmd_q.operand;
          mre_pkg::ModeSub: wr_data = rdata_q - cmd_q.operand;
          mre_pkg::ModeFill: wr_data = cmd_q.operand;
          default: wr_data = rdata_q;
        endcase
      end
      mre_pkg::StWriteB: begin
        wr_en   = 1'b1;
        wr_addr = addr_b;
        wr_data = a_q;
      end
      mre_pkg::StIdle: begin
        wr_en   = take && q_cmd_i.mode == mre_pkg::ModeWrite &&
                  q_cmd_i.status == mre_pkg::StatusOk;
        wr_addr = mre_pkg::elem_addr(q_cmd_i.top, q_cmd_i.left, 7'(q_cmd_i.row),
                                     7'(q_cmd_i.col));
        wr_data = q_cmd_i.operand;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= q_cmd_i;
    if (state_q == mre_pkg::StReadB) a_q <= rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mre_pkg::StIdle;
      r_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        r_q <= '0;
        c_q <= (q_cmd_i.mode == mre_pkg::ModeTrans) ? 7'd1 : 7'd0;
      end else if ((state_q == mre_pkg::StWriteA && !swap) ||
                   state_q == mre_pkg::StWriteB) begin
        r_q <= r_d;
        c_q <= c_d;
      end
    end
  end

  assign q_pop_o = take;

  // Result register parts the back end from the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == mre_pkg::StDone) begin
      res_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mre_pkg::StDone) begin
      res_status_q <= cmd_q.status;
      res_data_q   <= (cmd_q.mode == mre_pkg::ModeRead && cmd_q.status == mre_pkg::StatusOk)
                      ? rdata_q : '0;
    end
  end

  assign rsp.valid     = res_valid_q;
  assign rsp.read_data = res_data_q;
  assign rsp.status    = res_status_q;
endmodule

// ===== hw/rtl/mre_checker.sv =====
// Port-level checker for the matrix region engine, bound to the top level.
module mre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [31:0] rsp_read_data
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_status != 2'd3)
    else $error("reserved status code");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != 2'd0 |-> rsp_read_data == '0)
    else $error("read data nonzero on a failed command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_read_data) && $stable(rsp_status))
    else $error("result word changed while stalled");
endmodule

bind matrix_region_engine_core mre_checker u_mre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_read_data (rsp.read_data)
);

// ===== tb/sv/tb_matrix_region_engine_core.sv =====
// Self-checking testbench for the matrix region engine with a built-in matrix predictor.
module tb_matrix_region_engine_core;
  import mre_pkg::*;

  // Cycles without any handshake before the run is declared hung. The limit leaves a wide
  // margin over a full 64 by 64 scalar command and over the long receiver hold-off.
  localparam int unsigned WatchdogLimit = 60000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 32;

  typedef struct {
    logic [ElemWidth-1:0] read_data;
    status_e              status;
  } result_t;

  logic clk_i;
  logic rst_ni;

  mre_cmd_if cmd_ch ();
  mre_cfg_if cfg_ch ();
  mre_rsp_if rsp_ch ();

  matrix_region_engine_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd_ch.sink),
    .cfg    (cfg_ch.sink),
    .rsp    (rsp_ch.source)
  );

  // Shadow copy of the matrix and of the view registers.
  logic [ElemWidth-1:0] shadow_mat [MaxRows*MaxCols];
  logic [BoundW-1:0]    view_top, view_left, view_bottom, view_right;

  result_t pending_results [$];
  int      mismatch_count;
  int      idle_cycles;
  bit      calm_sender;   // when set the sender offers words back to back
  bit      calm_receiver; // when set the receiver never stalls
  bit      hold_off_req;  // asks the receiver for one long stall

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Number of view rows or columns after clamping the exclusive bound to the matrix.
  function automatic int view_extent(input int first, input int bound, input int limit);
    int b;
    begin
      b = (bound > limit) ? limit : bound;
      view_extent = (b > first) ? b - first : 0;
    end
  endfunction

  function automatic int cell_addr(input int r, input int c);
    cell_addr = ((view_top + r) * MaxCols + view_left + c) % (MaxRows * MaxCols);
  endfunction

  // Applies one command to the shadow matrix and returns the result it must produce.
  function automatic result_t apply_matrix_cmd(input mode_e m, input int r, input int c,
                                               input logic [ElemWidth-1:0] op);
    result_t res;
    int nr;
    int nc;
    int a;
    int b;
    logic [ElemWidth-1:0] tmp;
    begin
      nr = view_extent(view_top, view_bottom, MaxRows);
      nc = view_extent(view_left, view_right, MaxCols);
      res.read_data = '0;
      res.status    = StatusOk;
      case (m)
        ModeWrite, ModeRead: begin
          if (r >= nr || c >= nc) begin
            res.status = StatusOutside;
          end else if (m == ModeWrite) begin
            shadow_mat[cell_addr(r, c)] = op;
          end else begin
            res.read_data = shadow_mat[cell_addr(r, c)];
          end
        end
        ModeMul, ModeAdd, ModeSub, ModeFill: begin
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              a = cell_addr(i, j);
              case (m)
                ModeMul: shadow_mat[a] = shadow_mat[a] * op;
                ModeAdd: shadow_mat[a] = shadow_mat[a] + op;
                ModeSub: shadow_mat[a] = shadow_mat[a] - op;
                default: shadow_mat[a] = op;
              endcase
            end
          end
        end
        default: begin
          if (nr != nc || nr == 0) begin
            res.status = StatusShape;
          end else begin
            for (int i = 0; i + 1 < nr; i++) begin
              for (int j = 0; j < nr; j++) begin
                if (m == ModeTrans && j > i) begin
                  a = cell_addr(i, j);
                  b = cell_addr(j, i);
                end else if (m == ModeAntiTrans && i + j + 1 < nr) begin
                  a = cell_addr(i, j);
                  b = cell_addr(nr - 1 - j, nr - 1 - i);
                end else begin
                  continue;
                end
                tmp           = shadow_mat[a];
                shadow_mat[a] = shadow_mat[b];
                shadow_mat[b] = tmp;
              end
            end
          end
        end
      endcase
      apply_matrix_cmd = res;
    end
  endfunction

  // Sends one command word. Valid is left high after acceptance so that a back-to-back
  // word never needs valid to drop and rise in the same time step.
  task automatic send_cmd(input mode_e m, input int r, input int c,
                          input logic [ElemWidth-1:0] op);
    int gap;
    begin
      gap = calm_sender ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      cmd_ch.valid   <= 1'b1;
      cmd_ch.mode    <= m;
      cmd_ch.row     <= r[RowW-1:0];
      cmd_ch.col     <= c[ColW-1:0];
      cmd_ch.operand <= op;
      do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
      pending_results.push_back(apply_matrix_cmd(m, r, c, op));
    end
  endtask

  // Drops the command valid and waits until every expected result has come back.
  task automatic drain_engine();
    begin
      cmd_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val[BoundW-1:0];
      do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
      case (idx)
        CfgTopRow:    view_top    = val[BoundW-1:0];
        CfgLeftCol:   view_left   = val[BoundW-1:0];
        CfgBottomRow: view_bottom = val[BoundW-1:0];
        default:      view_right  = val[BoundW-1:0];
      endcase
    end
  endtask

  // Reprograms the whole view; only called once the engine has gone idle.
  task automatic set_view(input int t, input int l, input int b, input int r);
    begin
      drain_engine();
      write_reg(CfgTopRow, t);
      write_reg(CfgLeftCol, l);
      write_reg(CfgBottomRow, b);
      write_reg(CfgRightCol, r);
      cfg_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [ElemWidth-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       rand_operand = 32'h8000_0000;
      1:       rand_operand = 32'h7FFF_FFFF;
      2:       rand_operand = 32'hFFFF_FFFF;
      3:       rand_operand = 32'($urandom_range(0, 7)) - 32'd3;
      default: rand_operand = $urandom;
    endcase
  endfunction

  // The reset view spans the whole matrix. A full fill writes every entry, so no later
  // command can reach an entry that was never written. The directed words then hit the
  // corner cells, the extreme operands and every whole-matrix operation.
  task automatic test_full_matrix();
    begin
      send_cmd(ModeFill, 0, 0, 32'h8000_0000);
      send_cmd(ModeRead, 63, 63, '0);
      send_cmd(ModeWrite, 0, 0, 32'h7FFF_FFFF);
      send_cmd(ModeWrite, 63, 63, 32'h8000_0000);
      send_cmd(ModeWrite, 0, 63, 32'hFFFF_FFFF);
      send_cmd(ModeWrite, 63, 0, 32'h0000_0001);
      send_cmd(ModeRead, 0, 0, '0);
      send_cmd(ModeRead, 63, 63, '0);
      send_cmd(ModeMul, 5, 9, 32'hFFFF_FFFF);
      send_cmd(ModeAdd, 0, 0, 32'h7FFF_FFFF);
      send_cmd(ModeSub, 0, 0, 32'h8000_0000);
      send_cmd(ModeTrans, 0, 0, '0);
      send_cmd(ModeRead, 63, 0, '0);
      send_cmd(ModeAntiTrans, 0, 0, '0);
      send_cmd(ModeRead, 0, 0, '0);
      send_cmd(ModeRead, 0, 63, '0);
    end
  endtask

  // Empty, inverted, non-square and corner views, plus accesses just outside a view.
  task automatic test_view_edges();
    begin
      set_view(64, 64, 64, 64);
      send_cmd(ModeRead, 0, 0, '0);
      send_cmd(ModeFill, 0, 0, 32'h1234_5678);
      send_cmd(ModeTrans, 0, 0, '0);
      set_view(40, 10, 20, 63);
      send_cmd(ModeAdd, 0, 0, 32'd7);
      send_cmd(ModeAntiTrans, 0, 0, '0);
      set_view(60, 61, 64, 64);
      send_cmd(ModeTrans, 0, 0, '0);
      send_cmd(ModeWrite, 3, 2, 32'hDEAD_BEEF);
      send_cmd(ModeRead, 4, 0, '0);
      send_cmd(ModeWrite, 0, 3, 32'h0BAD_F00D);
      send_cmd(ModeRead, 3, 2, '0);
      set_view(0, 0, 63, 63);
      send_cmd(ModeAntiTrans, 0, 0, '0);
      send_cmd(ModeRead, 62, 62, '0);
      send_cmd(ModeRead, 63, 0, '0);
    end
  endtask

  // Random views, mostly small so region commands stay short, with random commands.
  task automatic test_random_views(input int phases);
    int t;
    int l;
    int h;
    int w;
    int cnt;
    int pick;
    mode_e m;
    begin
      for (int p = 0; p < phases; p++) begin
        t = $urandom_range(0, 64);
        l = $urandom_range(0, 64);
        h = $urandom_range(0, 6);
        w = ($urandom_range(0, 1) == 0) ? h : $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) begin
          set_view(t, l, $urandom_range(0, 64), $urandom_range(0, 64));
        end else begin
          set_view(t, l, t + h, l + w);
        end
        calm_sender   = ($urandom_range(0, 3) == 0);
        calm_receiver = ($urandom_range(0, 3) == 0);
        h   = view_extent(view_top, view_bottom, MaxRows);
        w   = view_extent(view_left, view_right, MaxCols);
        cnt = $urandom_range(10, 18);
        for (int k = 0; k < cnt; k++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            m = (pick < 3) ? ModeWrite : ModeRead;
          end else begin
            m = mode_e'($urandom_range(2, 7));
          end
          // Mostly in-view coordinates, sometimes anywhere in the field range.
          if ($urandom_range(0, 4) == 0 || h == 0 || w == 0) begin
            send_cmd(m, $urandom_range(0, 63), $urandom_range(0, 63), rand_operand());
          end else begin
            send_cmd(m, $urandom_range(0, h - 1), $urandom_range(0, w - 1), rand_operand());
          end
        end
      end
      calm_sender   = 1'b0;
      calm_receiver = 1'b0;
    end
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering words, so the
  // command queue fills up and the engine has to stall its input.
  task automatic test_backpressure();
    begin
      set_view(8, 8, 12, 12);
      calm_sender  = 1'b1;
      hold_off_req = 1'b1;
      for (int k = 0; k < 12; k++) begin
        send_cmd((k % 2 == 0) ? ModeWrite : ModeRead, k % 4, (k / 2) % 4, $urandom);
      end
      calm_sender = 1'b0;
    end
  endtask

  // Result side: random stalls per word, one long hold-off on request, field checks.
  initial begin
    int gap;
    result_t exp_res;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        gap = calm_receiver ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready));
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word: read_data %h status %0d",
                   rsp_ch.read_data, rsp_ch.status);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.read_data !== exp_res.read_data || rsp_ch.status !== exp_res.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected read_data %h status %0d, got %h status %0d",
                     exp_res.read_data, exp_res.status, rsp_ch.read_data, rsp_ch.status);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    calm_sender    = 1'b0;
    calm_receiver  = 1'b0;
    hold_off_req   = 1'b0;
    view_top       = '0;
    view_left      = '0;
    view_bottom    = 7'd64;
    view_right     = 7'd64;
    rst_ni         <= 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.mode    <= ModeWrite;
    cmd_ch.row     <= '0;
    cmd_ch.col     <= '0;
    cmd_ch.operand <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CfgTopRow;
    cfg_ch.data    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_matrix();
    test_view_edges();
    test_backpressure();
    test_random_views(8);

    drain_engine();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
